// ===== rtl/form_urlencoded_decoder_macros.svh =====
// Assertion macros used by the form-urlencoded decoder result buffer (fud_emit).
`ifndef FORM_URLENCODED_DECODER_MACROS_SVH
`define FORM_URLENCODED_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FUD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("form decoder check failed");

// Next-cycle implication, disabled while in reset.
`define FUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("form decoder check failed");

`endif

// ===== rtl/fud_pkg.sv =====
// Package with constants, types and helpers for the form-urlencoded decoder.
`timescale 1ns / 1ps
`default_nettype none
package fud_pkg;

  localparam int MAX_ITEMS = 4;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = $clog2(MAX_ITEMS);

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [1:0] KIND_KEY      = 2'd0;
  localparam logic [1:0] KIND_VALUE    = 2'd1;
  localparam logic [1:0] KIND_PAIR_END = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HEX  = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
  } fud_item_t;

  typedef struct packed {
    fud_item_t [MAX_ITEMS-1:0] items;
    logic [CNT_W-1:0]          cnt;
  } fud_bundle_t;

  function automatic logic fud_hex_ok(input logic [7:0] c);
    fud_hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
                 (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] fud_hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) begin
      fud_hex_val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      fud_hex_val = c[3:0] + 4'd9;
    end else begin
      fud_hex_val = 4'd0;
    end
  endfunction

  function automatic fud_item_t fud_mk(input logic [1:0] kind, input logic [7:0] data,
                                       input logic last);
    fud_item_t w;
    w.kind = kind;
    w.data = data;
    w.last = last;
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/fud_if.sv =====
// Valid/ready channel interfaces for the form-urlencoded decoder.
`timescale 1ns / 1ps
`default_nettype none
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_body;
  modport source (output valid, output in_byte, output end_of_body, input ready);
  modport sink   (input valid, input in_byte, input end_of_body, output ready);
endinterface

interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;
  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/form_urlencoded_decoder.sv =====
// Top level of the streaming form-urlencoded body decoder.
//
//   channel  port    direction  word
//   input    in_ch   sink       in_byte[8], end_of_body[1]
//   result   out_ch  source     kind[2], out_byte[8], last[1]
//
// One byte enters the input register per cycle while the buffer can load; decode
// runs between it and the result buffer. A byte gives zero to four words, sent one
// per cycle from the output register unless out_ch stalls; a byte waits in the
// input register until the buffer is empty or its last word is leaving. Words go
// from buffer to output register; output stalls back up through it to in_ch.ready.
// Reset is synchronous, active low; parse state returns to key part, no escape.
`timescale 1ns / 1ps
`default_nettype none
module form_urlencoded_decoder
  import fud_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  fud_in_if.sink     in_ch,
  fud_out_if.source  out_ch
);

  logic        inv_r;
  logic [7:0]  byte_r;
  logic        eob_r;
  logic        take;
  logic        can_load;
  fud_bundle_t bundle;

  assign take        = inv_r && can_load;
  assign in_ch.ready = !inv_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ch.ready) begin
      inv_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      byte_r <= in_ch.in_byte;
      eob_r  <= in_ch.end_of_body;
    end
  end

  fud_decode u_decode (
    .clk    (clk),
    .rst_n  (rst_n),
    .take   (take),
    .c      (byte_r),
    .eob    (eob_r),
    .bundle (bundle)
  );

  fud_emit u_emit (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .bundle   (bundle),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// ===== rtl/fud_decode.sv =====
// Per-byte decode: split, escape and plus handling with parse state.
`timescale 1ns / 1ps
`default_nettype none
module fud_decode
  import fud_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  c,
  input  wire logic        eob,
  output fud_bundle_t      bundle
);

  logic       vp_r, vp_nxt;
  logic [1:0] es_r, es_nxt;
  logic [7:0] held_r, held_nxt;

  logic       vp_w;
  logic [1:0] es_w;
  logic [7:0] held_w;
  logic [CNT_W-1:0] n;
  logic       bad;
  logic       hex;
  logic [1:0] dk;

  always_comb begin
    bundle = '0;
    n      = '0;
    vp_w   = vp_r;
    es_w   = es_r;
    held_w = held_r;
    bad    = 1'b0;
    hex    = fud_hex_ok(c);
    dk     = vp_r ? KIND_VALUE : KIND_KEY;
    if (c == CH_AMP) begin
      if (es_w == ESC_PCT || es_w == ESC_HEX) begin
        bundle.items[n[IDX_W-1:0]] = fud_mk(dk, CH_PCT, 1'b0);
        n = n + 1'b1;
      end
      if (es_w == ESC_HEX) begin
        bundle.items[n[IDX_W-1:0]] = fud_mk(dk, held_w, 1'b0);
        n = n + 1'b1;
      end
      es_w = ESC_NONE;
      held_w = '0;
      bundle.items[n[IDX_W-1:0]] = fud_mk(KIND_PAIR_END, 8'h00, eob);
      n = n + 1'b1;
      vp_w = 1'b0;
    end else begin
      if (c == CH_EQ && !vp_r) begin
        if (es_w == ESC_PCT || es_w == ESC_HEX) begin
          bundle.items[n[IDX_W-1:0]] = fud_mk(dk, CH_PCT, 1'b0);
          n = n + 1'b1;
        end
        if (es_w == ESC_HEX) begin
          bundle.items[n[IDX_W-1:0]] = fud_mk(dk, held_w, 1'b0);
          n = n + 1'b1;
        end
        es_w = ESC_NONE;
        held_w = '0;
        vp_w = 1'b1;
      end else begin
        case (es_r)
          ESC_PCT: begin
            if (hex) begin
              held_w = c;
              es_w = ESC_HEX;
            end else begin
              bundle.items[n[IDX_W-1:0]] = fud_mk(dk, CH_PCT, 1'b0);
              n = n + 1'b1;
              es_w = ESC_NONE;
              held_w = '0;
              bad = 1'b1;
            end
          end
          ESC_HEX: begin
            if (hex) begin
              bundle.items[n[IDX_W-1:0]] =
                fud_mk(dk, {fud_hex_val(held_r), fud_hex_val(c)}, 1'b0);
              n = n + 1'b1;
            end else begin
              bundle.items[n[IDX_W-1:0]] = fud_mk(dk, CH_PCT, 1'b0);
              n = n + 1'b1;
              bundle.items[n[IDX_W-1:0]] = fud_mk(dk, held_r, 1'b0);
              n = n + 1'b1;
              bad = 1'b1;
            end
            es_w = ESC_NONE;
            held_w = '0;
          end
          default: begin
            es_w = ESC_NONE;
            bad = 1'b1;
          end
        endcase
        if (bad) begin
          if (c == CH_PLUS) begin
            bundle.items[n[IDX_W-1:0]] = fud_mk(dk, CH_SPACE, 1'b0);
            n = n + 1'b1;
          end else if (c == CH_PCT) begin
            es_w = ESC_PCT;
          end else begin
            bundle.items[n[IDX_W-1:0]] = fud_mk(dk, c, 1'b0);
            n = n + 1'b1;
          end
        end
      end
      if (eob) begin
        if (es_w == ESC_PCT || es_w == ESC_HEX) begin
          bundle.items[n[IDX_W-1:0]] = fud_mk(vp_w ? KIND_VALUE : KIND_KEY, CH_PCT, 1'b0);
          n = n + 1'b1;
        end
        if (es_w == ESC_HEX) begin
          bundle.items[n[IDX_W-1:0]] = fud_mk(vp_w ? KIND_VALUE : KIND_KEY, held_w, 1'b0);
          n = n + 1'b1;
        end
        bundle.items[n[IDX_W-1:0]] = fud_mk(KIND_PAIR_END, 8'h00, 1'b1);
        n = n + 1'b1;
      end
    end
    bundle.cnt = n;
    if (eob) begin
      vp_nxt   = 1'b0;
      es_nxt   = ESC_NONE;
      held_nxt = '0;
    end else begin
      vp_nxt   = vp_w;
      es_nxt   = es_w;
      held_nxt = held_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r   <= 1'b0;
      es_r   <= ESC_NONE;
      held_r <= '0;
    end else if (take) begin
      vp_r   <= vp_nxt;
      es_r   <= es_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/fud_emit.sv =====
// Result buffer that serializes up to four words per byte into an output register.
`timescale 1ns / 1ps
`default_nettype none
`include "form_urlencoded_decoder_macros.svh"
module fud_emit
  import fud_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       load,
  input  wire fud_bundle_t bundle,
  output logic            can_load,
  fud_out_if.source       out_ch
);

  fud_item_t [MAX_ITEMS-1:0] items_r;
  logic [CNT_W-1:0] rem_r;
  logic [IDX_W-1:0] hd_r;
  logic             outv_r;
  fud_item_t        out_r;
  logic             out_load;
  logic             have;
  logic             pop;

  assign out_load = !outv_r || out_ch.ready;
  assign have     = (rem_r != '0);
  assign pop      = have && out_load;
  assign can_load = (rem_r == '0) || ((rem_r == CNT_W'(1)) && out_load);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      hd_r   <= '0;
      outv_r <= 1'b0;
    end else begin
      if (load) begin
        rem_r <= bundle.cnt;
        hd_r  <= '0;
      end else if (pop) begin
        rem_r <= rem_r - 1'b1;
        hd_r  <= hd_r + 1'b1;
      end
      if (out_load) begin
        outv_r <= have;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      items_r <= bundle.items;
    end
    if (pop) begin
      out_r <= items_r[hd_r];
    end
  end

  assign out_ch.valid    = outv_r;
  assign out_ch.kind     = out_r.kind;
  assign out_ch.out_byte = out_r.data;
  assign out_ch.last     = out_r.last;

  `FUD_ASSERT_NOW(a_rem_bound, clk, rst_n, 1'b1, rem_r <= CNT_W'(MAX_ITEMS))
  `FUD_ASSERT_NOW(a_head_bound, clk, rst_n, 1'b1, ({1'b0, hd_r} + rem_r) <= CNT_W'(MAX_ITEMS))
  `FUD_ASSERT_NOW(a_load_room, clk, rst_n, load, can_load)
  `FUD_ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, outv_r)

endmodule
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the streaming form-urlencoded body decoder.
`timescale 1ns / 1ps
module tb;
  import fud_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int ITEMS_WANTED  = 120;
  localparam int IDLE_PERCENT  = 14;
  localparam int DRAIN_CYCLES  = 20;

  class form_word_scoreboard;
    fud_item_t  expected_words[$];
    bit         value_part;
    logic [1:0] esc_stage;
    logic [7:0] held_char;
    int         words_this_byte;
    int         mismatches;
    int         words_checked;

    function void clear_state();
      value_part = 1'b0;
      esc_stage  = ESC_NONE;
      held_char  = 8'h00;
    endfunction

    function void push_word(logic [1:0] kind, logic [7:0] data, logic last);
      fud_item_t w;
      if (words_this_byte < MAX_ITEMS) begin
        w.kind = kind;
        w.data = data;
        w.last = last;
        expected_words.insert(expected_words.size(), w);
        words_this_byte++;
      end
    endfunction

    function void push_data(logic [7:0] data);
      push_word(value_part ? KIND_VALUE : KIND_KEY, data, 1'b0);
    endfunction

    function int hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "a" && c <= "f") return c - "a" + 10;
      if (c >= "A" && c <= "F") return c - "A" + 10;
      return -1;
    endfunction

    function void flush_escape();
      if (esc_stage == ESC_PCT) begin
        push_data(CH_PCT);
      end else if (esc_stage == ESC_HEX) begin
        push_data(CH_PCT);
        push_data(held_char);
      end
      esc_stage = ESC_NONE;
      held_char = 8'h00;
    endfunction

    function void plain_byte(logic [7:0] c);
      if (c == CH_PLUS) begin
        push_data(CH_SPACE);
      end else if (c == CH_PCT) begin
        esc_stage = ESC_PCT;
      end else begin
        push_data(c);
      end
    endfunction

    function void decode_data(logic [7:0] c);
      int lo;
      int hi;
      lo = hex_nibble(c);
      if (esc_stage == ESC_PCT) begin
        if (lo >= 0) begin
          held_char = c;
          esc_stage = ESC_HEX;
        end else begin
          flush_escape();
          plain_byte(c);
        end
      end else if (esc_stage == ESC_HEX) begin
        if (lo >= 0) begin
          hi = hex_nibble(held_char);
          if (hi < 0) hi = 0;
          push_data(8'((hi << 4) | lo));
          esc_stage = ESC_NONE;
          held_char = 8'h00;
        end else begin
          flush_escape();
          plain_byte(c);
        end
      end else begin
        esc_stage = ESC_NONE;
        plain_byte(c);
      end
    endfunction

    function void close_pair(logic last);
      flush_escape();
      push_word(KIND_PAIR_END, 8'h00, last);
      value_part = 1'b0;
    endfunction

    function void note_byte(logic [7:0] c, logic eob);
      words_this_byte = 0;
      if (c == CH_AMP) begin
        close_pair(eob);
      end else begin
        if (c == CH_EQ && !value_part) begin
          flush_escape();
          value_part = 1'b1;
        end else begin
          decode_data(c);
        end
        if (eob) close_pair(1'b1);
      end
      if (eob) clear_state();
    endfunction

    function void check_word(logic [1:0] kind, logic [7:0] data, logic last);
      fud_item_t exp_w;
      words_checked++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d byte=%02h last=%0b", $time, kind, data, last);
        mismatches++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (exp_w.kind !== kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, exp_w.kind, kind);
        mismatches++;
      end
      if (exp_w.data !== data) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, exp_w.data, data);
        mismatches++;
      end
      if (exp_w.last !== last) begin
        $display("%0t: last expected %0b actual %0b", $time, exp_w.last, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   steady;
  int   cycle_count = 0;
  int   items_sent;
  int   bytes_taken;
  int   bodies_taken;
  logic [7:0] body_bytes[$];
  form_word_scoreboard board = new();

  fud_in_if  in_ch();
  fud_out_if out_ch();

  form_urlencoded_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
             board.expected_words.size());
    $display("** form_urlencoded_decoder: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      board.note_byte(in_ch.in_byte, in_ch.end_of_body);
      bytes_taken++;
      if (in_ch.end_of_body) bodies_taken++;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      board.check_word(out_ch.kind, out_ch.out_byte, out_ch.last);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eob);
    while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.in_byte     <= b;
    in_ch.end_of_body <= eob;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit eob_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eob_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (board.expected_words.size() != 0) @(posedge clk);
  endtask

  function automatic void append_byte(input logic [7:0] b);
    body_bytes.insert(body_bytes.size(), b);
  endfunction

  function automatic logic [7:0] hex_char();
    string lo_set;
    string up_set;
    int n;
    lo_set = "0123456789abcdef";
    up_set = "0123456789ABCDEF";
    n = $urandom_range(0, 15);
    return $urandom_range(0, 1) ? up_set[n] : lo_set[n];
  endfunction

  function automatic void add_token();
    string plain;
    int r;
    plain = "abcxyzGKq019_.-~";
    r = $urandom_range(0, 99);
    if (r < 50) begin
      append_byte(plain[$urandom_range(0, plain.len() - 1)]);
    end else if (r < 62) begin
      append_byte(CH_PLUS);
    end else if (r < 80) begin
      append_byte(CH_PCT);
      append_byte(hex_char());
      append_byte(hex_char());
    end else if (r < 88) begin
      append_byte(CH_PCT);
      if ($urandom_range(0, 1)) append_byte(hex_char());
      append_byte(plain[$urandom_range(0, plain.len() - 1)]);
    end else if (r < 93) begin
      append_byte(CH_EQ);
    end else begin
      append_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_random_body();
    int pairs;
    int r;
    pairs = $urandom_range(1, 4);
    body_bytes.delete();
    for (int p = 0; p < pairs; p++) begin
      if (p > 0) append_byte(CH_AMP);
      repeat ($urandom_range(0, 4)) add_token();
      if ($urandom_range(0, 99) < 80) begin
        append_byte(CH_EQ);
        repeat ($urandom_range(0, 5)) add_token();
      end
    end
    r = $urandom_range(0, 99);
    if (r < 12) begin
      append_byte(CH_AMP);
    end else if (r < 22) begin
      append_byte(CH_PCT);
      if ($urandom_range(0, 1)) append_byte(hex_char());
    end
    if (body_bytes.size() == 0) append_byte("k");
    foreach (body_bytes[i]) send_byte(body_bytes[i], i == body_bytes.size() - 1);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    int directed_count;
    bit paused;
    rst_n             <= 1'b0;
    steady            <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.in_byte     <= 8'h00;
    in_ch.end_of_body <= 1'b0;
    items_sent   = 0;
    bytes_taken  = 0;
    bodies_taken = 0;
    paused       = 1'b0;
    board.clear_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_text("a%4F+=%e9=&&k%", 1'b1);
    send_text("%3=%2&", 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text("%+%4%", 1'b1);
    directed_count = items_sent;
    drain_results();

    while (items_sent < ITEMS_WANTED) begin
      steady <= (items_sent >= directed_count + 20) && (items_sent < directed_count + 50);
      if (!paused && items_sent >= directed_count + 60) begin
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 75) begin
        send_random_body();
      end else begin
        send_noise();
      end
    end
    steady <= 1'b0;
    in_ch.valid <= 1'b0;

    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Fed %0d body bytes (%0d bodies closed) and checked %0d decoded words",
             bytes_taken, bodies_taken, board.words_checked);
    $display("Stimulus mixed escapes, bad escapes, plus signs, empty pairs and raw noise");
    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("** form_urlencoded_decoder: PASSED **");
    end else begin
      $display("** form_urlencoded_decoder: FAILED **");
    end
    $finish;
  end

endmodule
